FILE: rtl/cbs_pkg.sv
// cbs_pkg: shared widths, types and the reciprocal table of the boxcar smoother
// used by every module of the block except cbs_ram; no dependencies
package cbs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HALF_W     = 5;
  localparam int CNT_W      = 6;              // window count, 1 .. 2*31+1
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W     = 6;
  localparam int SUM_W      = 22;             // 63 samples of 16 bits
  localparam int NUM_W      = SUM_W + 1;      // 2*|sum| + count
  localparam int RECIP_W    = 24;
  localparam int RECIP_SHIFT = 24;
  localparam int Q_W        = 17;
  localparam int DEN_W      = CNT_W + 1;
  localparam int PROD2_W    = Q_W + DEN_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam int RECIP_NUM = 2 ** 23;

  // floor(2^24 / (2*c)) for window count c; entry 0 is never used
  localparam logic [RECIP_W-1:0] RECIP [64] = '{
    24'd0,                  24'(RECIP_NUM / 1),  24'(RECIP_NUM / 2),  24'(RECIP_NUM / 3),
    24'(RECIP_NUM / 4),     24'(RECIP_NUM / 5),  24'(RECIP_NUM / 6),  24'(RECIP_NUM / 7),
    24'(RECIP_NUM / 8),     24'(RECIP_NUM / 9),  24'(RECIP_NUM / 10), 24'(RECIP_NUM / 11),
    24'(RECIP_NUM / 12),    24'(RECIP_NUM / 13), 24'(RECIP_NUM / 14), 24'(RECIP_NUM / 15),
    24'(RECIP_NUM / 16),    24'(RECIP_NUM / 17), 24'(RECIP_NUM / 18), 24'(RECIP_NUM / 19),
    24'(RECIP_NUM / 20),    24'(RECIP_NUM / 21), 24'(RECIP_NUM / 22), 24'(RECIP_NUM / 23),
    24'(RECIP_NUM / 24),    24'(RECIP_NUM / 25), 24'(RECIP_NUM / 26), 24'(RECIP_NUM / 27),
    24'(RECIP_NUM / 28),    24'(RECIP_NUM / 29), 24'(RECIP_NUM / 30), 24'(RECIP_NUM / 31),
    24'(RECIP_NUM / 32),    24'(RECIP_NUM / 33), 24'(RECIP_NUM / 34), 24'(RECIP_NUM / 35),
    24'(RECIP_NUM / 36),    24'(RECIP_NUM / 37), 24'(RECIP_NUM / 38), 24'(RECIP_NUM / 39),
    24'(RECIP_NUM / 40),    24'(RECIP_NUM / 41), 24'(RECIP_NUM / 42), 24'(RECIP_NUM / 43),
    24'(RECIP_NUM / 44),    24'(RECIP_NUM / 45), 24'(RECIP_NUM / 46), 24'(RECIP_NUM / 47),
    24'(RECIP_NUM / 48),    24'(RECIP_NUM / 49), 24'(RECIP_NUM / 50), 24'(RECIP_NUM / 51),
    24'(RECIP_NUM / 52),    24'(RECIP_NUM / 53), 24'(RECIP_NUM / 54), 24'(RECIP_NUM / 55),
    24'(RECIP_NUM / 56),    24'(RECIP_NUM / 57), 24'(RECIP_NUM / 58), 24'(RECIP_NUM / 59),
    24'(RECIP_NUM / 60),    24'(RECIP_NUM / 61), 24'(RECIP_NUM / 62), 24'(RECIP_NUM / 63)
  };

  // one classified sample, front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic [CNT_W-1:0]           pend;   // outputs pending once this sample is in
    logic                       emit;   // sample releases at least one output
  } job_t;

  // one mean to compute
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } div_req_t;

  typedef enum logic [1:0] {
    BK_TAKE,
    BK_EMIT,
    BK_SUB
  } back_state_t;

endpackage

FILE: rtl/cbs_ram.sv
// cbs_ram: generic one-write, one-read ram with registered read data
// no dependencies
module cbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cbs_queue.sv
// cbs_queue: short request queue between front and back
// depends on cbs_pkg
module cbs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbs_pkg::job_t push_item,
  output logic          full,
  input  logic          pop,
  output cbs_pkg::job_t pop_item,
  output logic          not_empty
);
  import cbs_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/cbs_front.sv
// cbs_front: accepts samples and marks how many outputs each one releases
// depends on cbs_pkg
module cbs_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear,
  input  logic [cbs_pkg::HALF_W-1:0]       half_window,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic signed [cbs_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                             s_tlast,
  input  logic                             q_full,
  output logic                             push,
  output cbs_pkg::job_t                    push_item
);
  import cbs_pkg::*;

  // samples of the log still waiting for their right side, capped at half_window
  logic [HALF_W-1:0] fill;
  logic [HALF_W-1:0] fill_next;
  logic              at_half;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;
  assign at_half  = (fill == half_window);

  always_comb begin
    push_item.sample = s_tdata;
    push_item.last   = s_tlast;
    push_item.pend   = CNT_W'(fill) + 1'b1;
    push_item.emit   = s_tlast || at_half;
  end

  always_comb begin
    if (s_tlast) begin
      fill_next = '0;
    end else if (at_half) begin
      fill_next = fill;
    end else begin
      fill_next = fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (push) begin
      fill <= fill_next;
    end
  end

endmodule

FILE: rtl/cbs_div.sv
// cbs_div: rounded mean, sum / count to nearest with ties away from zero
// reciprocal multiply plus one correction step; depends on cbs_pkg
module cbs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cbs_pkg::div_req_t                 in_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cbs_pkg::SAMPLE_W-1:0] out_mean,
  output logic                              out_last
);
  import cbs_pkg::*;

  logic adv;
  logic v1, v2, v3;

  // stage 1: numerator, denominator, reciprocal
  logic [NUM_W-1:0]   n1;
  logic [RECIP_W-1:0] r1;
  logic [DEN_W-1:0]   d1;
  logic               neg1, last1;
  // stage 2: estimate
  logic [NUM_W-1:0]   n2;
  logic [DEN_W-1:0]   d2;
  logic [Q_W-1:0]     q2;
  logic               neg2, last2;
  // stage 3: estimate times denominator
  logic [NUM_W-1:0]   n3;
  logic [DEN_W-1:0]   d3;
  logic [Q_W-1:0]     q3;
  logic [PROD2_W-1:0] p3;
  logic               neg3, last3;

  logic                  in_neg;
  logic [SUM_W-1:0]      in_mag;
  logic [NUM_W+RECIP_W-1:0] prod1;
  logic [PROD2_W-1:0]    rem;
  logic [Q_W-1:0]        qf;
  logic [Q_W-1:0]        qs;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign in_neg = in_req.sum[SUM_W-1];
  assign in_mag = in_neg ? SUM_W'(-in_req.sum) : SUM_W'(in_req.sum);
  assign prod1  = (NUM_W+RECIP_W)'(n1) * (NUM_W+RECIP_W)'(r1);
  assign rem    = PROD2_W'(n3) - p3;
  assign qf     = (rem >= PROD2_W'(d3)) ? q3 + 1'b1 : q3;
  assign qs     = neg3 ? -qf : qf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1    <= {in_mag, 1'b0} + NUM_W'(in_req.cnt);
      r1    <= RECIP[in_req.cnt];
      d1    <= {in_req.cnt, 1'b0};
      neg1  <= in_neg;
      last1 <= in_req.last;

      n2    <= n1;
      d2    <= d1;
      q2    <= prod1[RECIP_SHIFT +: Q_W];
      neg2  <= neg1;
      last2 <= last1;

      n3    <= n2;
      d3    <= d2;
      q3    <= q2;
      p3    <= PROD2_W'(q2) * PROD2_W'(d2);
      neg3  <= neg2;
      last3 <= last2;

      out_mean <= qs[SAMPLE_W-1:0];
      out_last <= last3;
    end
  end

endmodule

FILE: rtl/cbs_back.sv
// cbs_back: keeps the window store and running sum, issues one mean per output
// depends on cbs_pkg, cbs_ram
module cbs_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [cbs_pkg::HALF_W-1:0] half_window,
  input  logic                       q_valid,
  input  cbs_pkg::job_t              q_item,
  output logic                       q_pop,
  output logic                       div_valid,
  input  logic                       div_ready,
  output cbs_pkg::div_req_t          div_req
);
  import cbs_pkg::*;

  back_state_t             state;
  back_state_t             state_next;
  logic signed [SUM_W-1:0] sum;
  logic [ADDR_W-1:0]       wp;
  logic [HALF_W-1:0]       lcount;   // left side of the window, capped at half_window
  logic [CNT_W-1:0]        rem;      // outputs still pending for this sample
  logic                    job_last;

  logic                    ram_we;
  logic [ADDR_W-1:0]       raddr;
  logic [SAMPLE_W-1:0]     rdata;
  logic                    left_full;
  logic                    more;

  assign left_full = (lcount == half_window);
  assign more      = job_last && (rem != CNT_W'(1));
  // oldest sample of the window about to be emitted
  assign raddr     = wp - ADDR_W'(rem) - ADDR_W'(half_window);

  cbs_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(q_item.sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    div_req.sum  = sum;
    div_req.cnt  = CNT_W'(lcount) + rem;
    div_req.last = job_last && (rem == CNT_W'(1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_TAKE: begin
        if (q_valid && q_item.emit) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (div_ready) begin
          if (left_full) begin
            state_next = BK_SUB;
          end else if (!more) begin
            state_next = BK_TAKE;
          end
        end
      end
      BK_SUB: begin
        state_next = more ? BK_EMIT : BK_TAKE;
      end
      default: state_next = BK_TAKE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    div_valid = 1'b0;
    unique case (state)
      BK_TAKE: begin
        q_pop  = q_valid;
        ram_we = q_valid;
      end
      BK_EMIT: begin
        div_valid = 1'b1;
      end
      BK_SUB: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state  <= BK_TAKE;
      sum    <= '0;
      wp     <= '0;
      lcount <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        BK_TAKE: begin
          if (q_valid) begin
            sum <= sum + SUM_W'(q_item.sample);
            wp  <= wp + 1'b1;
          end
        end
        BK_EMIT: begin
          if (div_ready && !left_full) begin
            lcount <= lcount + 1'b1;
            if (job_last && !more) begin
              // end of log: start the next one clean
              sum    <= '0;
              wp     <= '0;
              lcount <= '0;
            end
          end
        end
        BK_SUB: begin
          if (job_last && !more) begin
            sum    <= '0;
            wp     <= '0;
            lcount <= '0;
          end else begin
            sum <= sum - SUM_W'($signed(rdata));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_TAKE && q_valid) begin
      rem      <= q_item.pend;
      job_last <= q_item.last;
    end else if ((state == BK_EMIT && div_ready && !left_full && more) ||
                 (state == BK_SUB && more)) begin
      rem <= rem - 1'b1;
    end
  end

endmodule

FILE: rtl/centered_boxcar_smoother_top.sv
// centered_boxcar_smoother_top: centered moving average with truncated edges
// depends on cbs_pkg, cbs_front, cbs_queue, cbs_back, cbs_div, cbs_ram
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata = sample (16 signed), s_tlast = last_sample
//   m_*       out  m_tvalid/m_tready  m_tdata = smoothed (16 signed), m_tlast = last_result
//   cfg_*     in   cfg_wr_en          cfg_wr_data = half_window (5)
//
// the front takes one request per cycle into a four-entry queue until it is full; the back
// takes a request in BK_TAKE, emits each output in BK_EMIT, plus BK_SUB (store read, sum
// update) once the window's left side is full; the end-of-log flush releases up to
// half_window+1 outputs; the mean comes from a four-stage reciprocal divider whose last
// stage is the output reg; a stalled m_tready holds the divider, then the back, then fills
// the queue; rst is synchronous; a half_window write clears the front and back state
module centered_boxcar_smoother_top (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [cbs_pkg::HALF_W-1:0]         cfg_wr_data,  // half_window
  // sample stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [cbs_pkg::SAMPLE_W-1:0] s_tdata,     // [15:0] sample
  input  logic                               s_tlast,      // last_sample
  // smoothed stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic signed [cbs_pkg::SAMPLE_W-1:0] m_tdata,     // [15:0] smoothed
  output logic                               m_tlast       // last_result
);
  import cbs_pkg::*;

  logic [HALF_W-1:0] half_window;

  // front to queue
  logic     push;
  job_t     push_item;
  logic     q_full;
  // queue to back
  logic     q_pop;
  job_t     q_item;
  logic     q_valid;
  // back to divider
  logic     div_valid;
  logic     div_ready;
  div_req_t div_req;

  // a 5-bit half window never exceeds the 31-sample maximum, so no clamp is needed
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= '0;
    end else if (cfg_wr_en) begin
      half_window <= cfg_wr_data;
    end
  end

  cbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_wr_en),
    .half_window(half_window),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  // decouples request intake from the window arithmetic
  cbs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .pop_item (q_item),
    .not_empty(q_valid)
  );

  cbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_wr_en),
    .half_window(half_window),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .div_valid  (div_valid),
    .div_ready  (div_ready),
    .div_req    (div_req)
  );

  // rounded mean; its last stage drives the output channel directly
  cbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_ready (div_ready),
    .in_req   (div_req),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_mean (m_tdata),
    .out_last (m_tlast)
  );

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for centered_boxcar_smoother_top
// holds a bit-true smoother model in a small scoreboard class; uses cbs_pkg for widths
`timescale 1ns / 100ps

module tb_top;
  import cbs_pkg::*;

  // one smoothed result as the block presents it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic                       last_result;
  } mean_t;

  // running model of the smoother plus the queue of means still owed by the block
  class boxcar_board;
    logic signed [SAMPLE_W-1:0] window [STORE_DEPTH];
    longint                     sum_acc = 0;
    logic [15:0]                seen = '0;
    logic [15:0]                out_idx = '0;
    bit                         out_wrapped = 1'b0;
    int unsigned                wr_pos = 0;
    int unsigned                half = 0;
    mean_t                      due [$];
    int unsigned                errors = 0;

    function void clear_log();
      sum_acc     = 0;
      seen        = '0;
      out_idx     = '0;
      out_wrapped = 1'b0;
      wr_pos      = 0;
    endfunction

    // a half_window write restarts the log and drops whatever was pending
    function void set_half_window(logic [HALF_W-1:0] h);
      half = h;
      clear_log();
    endfunction

    // round to nearest, ties away from zero
    function logic signed [SAMPLE_W-1:0] rounded_mean(longint s, int unsigned n);
      longint mag;
      longint q;
      mag = (s < 0) ? -s : s;
      q = (2 * mag + n) / (2 * n);
      return (s < 0) ? -q : q;
    endfunction

    function void emit_mean(int unsigned pend, int unsigned right, bit last);
      int unsigned left;
      int unsigned slot;
      mean_t       m;
      // left side grows from the start of the log, full for good once the index wraps
      left = out_wrapped ? half : ((out_idx < half) ? out_idx : half);
      m.smoothed    = rounded_mean(sum_acc, left + right + 1);
      m.last_result = last;
      due.push_back(m);
      if (left == half) begin
        slot = (wr_pos + STORE_DEPTH - ((pend + half) % STORE_DEPTH)) % STORE_DEPTH;
        sum_acc -= window[slot];
      end
      out_idx++;
      if (out_idx == 0) out_wrapped = 1'b1;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s, bit last);
      logic [15:0] diff;
      int unsigned pend;
      window[wr_pos] = s;
      wr_pos = (wr_pos + 1) % STORE_DEPTH;
      sum_acc += s;
      seen++;
      diff = seen - out_idx;
      pend = diff;
      if (!last) begin
        if (pend > half) emit_mean(pend, half, 1'b0);
      end else begin
        // end of log: flush everything pending, right side shrinking to nothing
        while (pend > 0) begin
          emit_mean(pend, pend - 1, pend == 1);
          pend--;
        end
        clear_log();
      end
    endfunction

    function void check_mean(logic signed [SAMPLE_W-1:0] got, logic got_last);
      mean_t want;
      if (due.size() == 0) begin
        $error("smoothed: expected nothing, got %0d (last_result %0b)", got, got_last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got !== want.smoothed) begin
        $error("smoothed: expected %0d, got %0d", want.smoothed, got);
        errors++;
      end
      if (got_last !== want.last_result) begin
        $error("last_result: expected %0b, got %0b", want.last_result, got_last);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [HALF_W-1:0]          cfg_wr_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic signed [SAMPLE_W-1:0] s_tdata = '0;     // [15:0] sample
  logic                       s_tlast = 1'b0;   // last_sample
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic signed [SAMPLE_W-1:0] m_tdata;          // [15:0] smoothed
  logic                       m_tlast;          // last_result

  boxcar_board board = new;

  // idle rates in percent, changed per stimulus phase
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  centered_boxcar_smoother_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: values seen here are the ones that held across the edge,
  // since every bench input changes only through nonblocking assignments
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_mean(m_tdata, m_tlast);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one sample request, with random gaps ahead of it; the model sees it on acceptance
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input bit last);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.take_sample(v, last);
  endtask

  // stop sending until the block has delivered every mean owed so far
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
  endtask

  // registers change only with the block idle; requests with no result may
  // still sit in the four-entry queue or the back end, hence the extra cycles
  task automatic write_half(input logic [HALF_W-1:0] h);
    wait_results_done();
    repeat (30) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.set_half_window(h);
  endtask

  // flavor 1 and 2 push the running sum to its full-scale limits
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int flavor);
    if (flavor == 1) return 16'sh8000;
    if (flavor == 2) return 16'sh7fff;
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1:       return 16'($urandom_range(20)) - 16'd10;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] pick_half();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 5'd31;
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  initial begin
    int  budget;
    int  len;
    int  flavor;
    bit  abort;
    bit  paused;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // half window 0 straight out of reset: every sample is its own mean
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd5, 1'b1);
    // a log of a single sample
    send_sample(16'sd1234, 1'b1);

    // widest window on a log shorter than the window: all means come from the flush
    write_half(5'd31);
    repeat (5) send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);

    // rounding ties on both signs: +0.5 -> 1, -0.5 -> -1
    write_half(5'd1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b1);

    // a log cut off by a register write, with the sender held until caught up
    write_half(5'd2);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd11, 1'b0);
    wait_results_done();
    send_sample(16'sd13, 1'b0);
    write_half(5'd3);

    // --- random logs under three idling patterns ---
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin send_gap_pct = 14; recv_stall_pct = 45; end
        1:       begin send_gap_pct = 45; recv_stall_pct = 14; end
        default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      budget = 110;
      paused = 1'b0;
      while (budget > 0) begin
        if ($urandom_range(2) == 0) write_half(pick_half());
        len    = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 70);
        flavor = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0;
        abort  = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
          // hold the sender once per pattern (and now and then) until caught up
          if (i == len / 2 && len > 2 && (!paused || $urandom_range(7) == 0)) begin
            wait_results_done();
            paused = 1'b1;
          end
          send_sample(pick_sample(flavor), !abort && i == len - 1);
        end
        // an unfinished log gets thrown away by the next register write
        if (abort) write_half(pick_half());
        budget -= len;
      end
    end

    wait_results_done();
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("** centered_boxcar_smoother_top: PASSED **");
    end else begin
      $display("** centered_boxcar_smoother_top: FAILED **");
    end
    $finish;
  end

  // timeout with a wide margin over the length of a full run
  initial begin
    #10_000_000;
    $display("** centered_boxcar_smoother_top: FAILED **");
    $finish;
  end

endmodule
